// ===== hw/rtl/tap_tempo_swell_envelope_core_defines.svh =====
// Assertion macros for the tap tempo swell core.
`ifndef TAP_TEMPO_SWELL_ENVELOPE_CORE_DEFINES_SVH
`define TAP_TEMPO_SWELL_ENVELOPE_CORE_DEFINES_SVH

// Check a consequence in the same cycle.
`define TTSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle.
`define TTSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ttse_pkg.sv =====
package ttse_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_RISE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TAP_GAP = 2'd2;

  localparam logic [6:0] RST_LEVEL_RISE  = 7'd4;
  localparam logic [6:0] RST_START_LEVEL = 7'd10;
  localparam logic [7:0] RST_MAX_TAP_GAP = 8'd32;

  localparam logic [6:0]  LEVEL_MAX    = 7'd127;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [5:0]  INTERVAL_MAX = 6'd63;
  localparam logic [6:0]  TRACK_OFFSET = 7'd40;

  localparam logic OP_TAP  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_CC    = 2'd1;
  localparam logic [1:0] ACT_TRACK = 2'd2;

  // divider widths for taps: num 2*sum+count, den 2*count
  localparam int DIV_NUM_W = 18;
  localparam int DIV_DEN_W = 17;

  typedef enum logic [2:0] {
    EV_NOTE_ON  = 3'd0,
    EV_CC       = 3'd1,
    EV_TRACK    = 3'd2,
    EV_NOTE_OFF = 3'd3,
    EV_ALL_OFF  = 3'd4
  } ttse_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DSTART,
    S_DIV,
    S_FIN,
    S_EMIT
  } ttse_state_e;

  typedef struct packed {
    logic        operation;
    logic [2:0]  channel;
    logic [31:0] beat_position;
    logic        footswitch_held;
    logic [1:0]  action_kind;
    logic        track_playing;
  } ttse_req_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [2:0]        event_channel;
    logic signed [7:0] event_value;
    logic              last_event;
  } ttse_evt_t;

  typedef struct packed {
    logic        running;
    logic [15:0] tap_count;
    logic [6:0]  swell_level;
    logic [15:0] gap_sum;
    logic [5:0]  beat_step;
    logic [5:0]  repeat_interval;
    logic [31:0] last_tap_position;
  } ttse_entry_t;

  localparam int ENTRY_W = $bits(ttse_entry_t);

  localparam ttse_entry_t ENTRY_RESET = '{
    running:           1'b0,
    tap_count:         16'd0,
    swell_level:       RST_START_LEVEL,
    gap_sum:           16'd0,
    beat_step:         6'd0,
    repeat_interval:   6'd1,
    last_tap_position: 32'd0
  };

endpackage

// ===== hw/rtl/tap_tempo_swell_envelope_core.sv =====
// A request that needs the 18-step divider (later taps inside the gap limit with a nonzero
// tap count, every tick on a running channel) goes S_CALC, S_DSTART, S_DIV, S_FIN, S_EMIT;
// other taps skip the divider, and a tick on an idle channel returns to idle from S_CALC.
// S_EMIT follows S_FIN only when events were made. A request is taken only while idle.
// Results come on evt_strobe_o, one per cycle, and cannot be stalled.
// Reset: all channels idle at start level 10, interval 1; registers 4, 10, 32.
`include "tap_tempo_swell_envelope_core_defines.svh"

module tap_tempo_swell_envelope_core #(
  parameter int CHANNELS = ttse_pkg::NUM_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  ttse_pkg::ttse_req_t                 req_i,
  output logic                                evt_strobe_o,
  output ttse_pkg::ttse_evt_t                 evt_o,
  input  logic                                cfg_we_i,
  input  logic [ttse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttse_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  import ttse_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ttse_state_e state_q, state_d;

  logic [6:0] level_rise_q, level_rise_d;
  logic [6:0] start_level_q, start_level_d;
  logic [7:0] max_gap_q, max_gap_d;
  logic signed [6:0] last_track_q, last_track_d;

  logic [CHANNELS-1:0] valid_q, valid_d;
  logic                rd_valid_q, rd_valid_d;

  ttse_req_t   req_q, req_d;
  ttse_entry_t rec_q, rec_d;
  logic        arm_q, arm_d;
  logic        use_div_q, use_div_d;
  ttse_evt_t   ev_q [3];
  ttse_evt_t   ev_d [3];
  logic [1:0]  ev_n_q, ev_n_d;
  logic [1:0]  ev_idx_q, ev_idx_d;
  logic [1:0]  fin_n;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;
  ttse_entry_t       wr_entry;
  ttse_entry_t       cur;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem;

  logic        accept;
  logic        in_range;
  logic [31:0] gap;
  logic        gap_ok;
  logic [15:0] tcount_new;
  logic [7:0]  level_sum;
  logic [6:0]  level_new;
  logic [16:0] sum_ext;
  logic [15:0] sum_new;
  logic        tap_div;
  logic [5:0]  iv;
  logic [7:0]  tl_ext;
  logic signed [6:0] tl;

  assign in_range  = 32'(req_i.channel) < CHANNELS;
  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign ram_re    = accept && in_range;
  assign ram_raddr = AW'(req_i.channel);
  assign ram_waddr = AW'(req_q.channel);

  ttse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ttse_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // untouched entries read as their reset value
  assign cur = rd_valid_q ? ttse_entry_t'(ram_rdata) : ENTRY_RESET;

  assign gap        = req_q.beat_position - cur.last_tap_position;
  assign gap_ok     = gap <= 32'(max_gap_q);
  assign tcount_new = (req_q.footswitch_held || cur.tap_count == COUNT_MAX) ?
                      cur.tap_count : cur.tap_count + 16'd1;
  assign level_sum  = {1'b0, cur.swell_level} + {1'b0, level_rise_q};
  assign level_new  = req_q.footswitch_held ? cur.swell_level :
                      (level_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_sum[6:0];
  assign sum_ext    = {1'b0, cur.gap_sum} + {9'd0, gap[7:0]};
  assign sum_new    = sum_ext[16] ? COUNT_MAX : sum_ext[15:0];
  assign tap_div    = cur.running && gap_ok && (tcount_new != 16'd0);

  assign iv     = (rec_q.repeat_interval == 6'd0) ? 6'd1 : rec_q.repeat_interval;
  assign tl_ext = {1'b0, rec_q.swell_level} - {1'b0, TRACK_OFFSET};
  assign tl     = (rec_q.swell_level >= TRACK_OFFSET) ? 7'sd0 : $signed(tl_ext[6:0]);

  assign div_num = (req_q.operation == OP_TICK) ?
                   (DIV_NUM_W'(rec_q.beat_step) + DIV_NUM_W'(1)) :
                   (DIV_NUM_W'({rec_q.gap_sum, 1'b0}) + DIV_NUM_W'(rec_q.tap_count));
  assign div_den = (req_q.operation == OP_TICK) ? DIV_DEN_W'(iv) :
                   DIV_DEN_W'({rec_q.tap_count, 1'b0});

  always_comb begin
    level_rise_d  = level_rise_q;
    start_level_d = start_level_q;
    max_gap_d     = max_gap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL_RISE:  level_rise_d  = cfg_wdata_i[6:0];
        CFG_START_LEVEL: start_level_d = cfg_wdata_i[6:0];
        CFG_MAX_TAP_GAP: max_gap_d     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ram_re) state_d = S_CALC;
      end
      S_CALC: begin
        if (req_q.operation == OP_TICK) begin
          state_d = cur.running ? S_DSTART : S_IDLE;
        end else begin
          state_d = tap_div ? S_DSTART : S_FIN;
        end
      end
      S_DSTART: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_FIN;
      end
      S_FIN: state_d = (fin_n != 2'd0) ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (ev_idx_q == ev_n_q - 2'd1) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ttse_entry_t e;
    logic [1:0]  n;
    ttse_evt_t   ev;
    req_d        = req_q;
    rd_valid_d   = rd_valid_q;
    valid_d      = valid_q;
    rec_d        = rec_q;
    arm_d        = arm_q;
    use_div_d    = use_div_q;
    ev_d         = ev_q;
    ev_n_d       = ev_n_q;
    ev_idx_d     = ev_idx_q;
    last_track_d = last_track_q;
    ram_we       = 1'b0;
    wr_entry     = rec_q;
    div_start    = 1'b0;
    fin_n        = 2'd0;
    e            = rec_q;
    n            = 2'd0;
    ev           = '0;
    unique case (state_q)
      S_IDLE: begin
        if (ram_re) begin
          req_d      = req_i;
          rd_valid_d = valid_q[ram_raddr];
        end
      end
      S_CALC: begin
        rec_d     = cur;
        arm_d     = 1'b0;
        use_div_d = (req_q.operation == OP_TICK);
        if (req_q.operation == OP_TAP) begin
          if (!cur.running) begin
            rec_d.running           = 1'b1;
            rec_d.last_tap_position = req_q.beat_position;
            arm_d                   = 1'b1;
          end else begin
            rec_d.tap_count   = tcount_new;
            rec_d.swell_level = level_new;
            if (gap_ok) begin
              rec_d.gap_sum           = sum_new;
              rec_d.last_tap_position = req_q.beat_position;
            end
            use_div_d = tap_div;
          end
        end
      end
      S_DSTART: div_start = 1'b1;
      S_DIV: ;
      S_FIN: begin
        ev.event_channel = req_q.channel;
        if (req_q.operation == OP_TAP) begin
          if (use_div_q) begin
            if (div_quo > DIV_NUM_W'(INTERVAL_MAX)) begin
              e.repeat_interval = INTERVAL_MAX;
            end else if (div_quo == '0) begin
              e.repeat_interval = 6'd1;
            end else begin
              e.repeat_interval = div_quo[5:0];
            end
          end
          if (arm_q) begin
            ev.event_kind  = EV_NOTE_ON;
            ev.event_value = 8'sd0;
            ev_d[n]        = ev;
            n              = n + 2'd1;
          end
        end else begin
          e.beat_step = div_rem[5:0];
          if (div_rem[5:0] == 6'd0) begin
            if (req_q.action_kind == ACT_CC) begin
              if (!req_q.footswitch_held) begin
                ev.event_kind  = EV_CC;
                ev.event_value = $signed({1'b0, rec_q.swell_level});
                ev_d[n]        = ev;
                n              = n + 2'd1;
              end
            end else if (req_q.action_kind == ACT_TRACK) begin
              if (req_q.track_playing) begin
                if (tl != last_track_q) begin
                  ev.event_kind  = EV_TRACK;
                  ev.event_value = 8'(tl);
                  ev_d[n]        = ev;
                  n              = n + 2'd1;
                end
                last_track_d = tl;
              end
            end
            if (rec_q.swell_level != 7'd0) begin
              if (!req_q.footswitch_held) e.swell_level = rec_q.swell_level - 7'd1;
            end else begin
              e.running     = 1'b0;
              e.tap_count   = 16'd0;
              e.swell_level = start_level_q;
              e.gap_sum     = 16'd0;
              e.beat_step   = 6'd0;
              ev.event_kind  = EV_NOTE_OFF;
              ev.event_value = 8'sd0;
              ev_d[n]        = ev;
              ev.event_kind    = EV_ALL_OFF;
              ev.event_channel = 3'd0;
              ev_d[n + 2'd1]   = ev;
              n                = n + 2'd2;
            end
          end
        end
        wr_entry = e;
        ram_we   = 1'b1;
        valid_d[ram_waddr] = 1'b1;
        fin_n    = n;
        ev_n_d   = n;
        ev_idx_d = 2'd0;
      end
      S_EMIT: ev_idx_d = ev_idx_q + 2'd1;
      default: ;
    endcase
  end

  always_comb begin
    evt_o            = ev_q[ev_idx_q];
    evt_o.last_event = (ev_idx_q == ev_n_q - 2'd1);
  end
  assign evt_strobe_o = (state_q == S_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      level_rise_q  <= RST_LEVEL_RISE;
      start_level_q <= RST_START_LEVEL;
      max_gap_q     <= RST_MAX_TAP_GAP;
      last_track_q  <= 7'sd0;
      valid_q       <= '0;
      rd_valid_q    <= 1'b0;
      arm_q         <= 1'b0;
      use_div_q     <= 1'b0;
      ev_n_q        <= 2'd0;
      ev_idx_q      <= 2'd0;
    end else begin
      state_q       <= state_d;
      level_rise_q  <= level_rise_d;
      start_level_q <= start_level_d;
      max_gap_q     <= max_gap_d;
      last_track_q  <= last_track_d;
      valid_q       <= valid_d;
      rd_valid_q    <= rd_valid_d;
      arm_q         <= arm_d;
      use_div_q     <= use_div_d;
      ev_n_q        <= ev_n_d;
      ev_idx_q      <= ev_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rec_q <= rec_d;
    ev_q  <= ev_d;
  end

  `TTSE_ASSERT_SAME(a_no_rw_overlap, ram_we, !ram_re, "state read overlaps write-back")
  `TTSE_ASSERT_NEXT(a_idle_after_last, evt_strobe_o && evt_o.last_event, !busy, "busy after final event")
  `TTSE_ASSERT_SAME(a_div_done_in_div, div_done, state_q == S_DIV, "divider result outside wait state")
  `TTSE_ASSERT_SAME(a_interval_nonzero, ram_we, wr_entry.repeat_interval != 6'd0, "zero interval written")

endmodule

// ===== hw/rtl/ttse_ram.sv =====
module ttse_ram #(
  parameter int WIDTH = ttse_pkg::ENTRY_W,
  parameter int DEPTH = ttse_pkg::NUM_CHANNELS
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/ttse_div.sv =====
module ttse_div #(
  parameter int NUM_W = ttse_pkg::DIV_NUM_W,
  parameter int DEN_W = ttse_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
